### hdl/mie_pkg.sv
// Shared types and instruction encodings for the MIPS instruction execute block.
package mie_pkg;

  // Program counter after reset
  localparam logic [31:0] START_RESET = 32'h0040_0000;
  // Register that the exit syscall tests, the return address register, and the code that means exit
  localparam logic [4:0]  REG_V0      = 5'd2;
  localparam logic [4:0]  REG_RA      = 5'd31;
  localparam logic [31:0] EXIT_CODE   = 32'd10;

  // Primary opcodes
  localparam logic [5:0] OP_SPECIAL = 6'd0;
  localparam logic [5:0] OP_REGIMM  = 6'd1;
  localparam logic [5:0] OP_J       = 6'd2;
  localparam logic [5:0] OP_JAL     = 6'd3;
  localparam logic [5:0] OP_BEQ     = 6'd4;
  localparam logic [5:0] OP_BNE     = 6'd5;
  localparam logic [5:0] OP_BLEZ    = 6'd6;
  localparam logic [5:0] OP_BGTZ    = 6'd7;
  localparam logic [5:0] OP_ADDI    = 6'd8;
  localparam logic [5:0] OP_ADDIU   = 6'd9;
  localparam logic [5:0] OP_SLTI    = 6'd10;
  localparam logic [5:0] OP_SLTIU   = 6'd11;
  localparam logic [5:0] OP_ANDI    = 6'd12;
  localparam logic [5:0] OP_ORI     = 6'd13;
  localparam logic [5:0] OP_XORI    = 6'd14;
  localparam logic [5:0] OP_LUI     = 6'd15;
  localparam logic [5:0] OP_LB      = 6'd32;
  localparam logic [5:0] OP_LH      = 6'd33;
  localparam logic [5:0] OP_LW      = 6'd35;
  localparam logic [5:0] OP_LBU     = 6'd36;
  localparam logic [5:0] OP_LHU     = 6'd37;
  localparam logic [5:0] OP_SB      = 6'd40;
  localparam logic [5:0] OP_SH      = 6'd41;
  localparam logic [5:0] OP_SW      = 6'd43;

  // Function codes of the special opcode
  localparam logic [5:0] FN_SLL     = 6'd0;
  localparam logic [5:0] FN_SRL     = 6'd2;
  localparam logic [5:0] FN_SRA     = 6'd3;
  localparam logic [5:0] FN_SLLV    = 6'd4;
  localparam logic [5:0] FN_SRLV    = 6'd6;
  localparam logic [5:0] FN_SRAV    = 6'd7;
  localparam logic [5:0] FN_JR      = 6'd8;
  localparam logic [5:0] FN_JALR    = 6'd9;
  localparam logic [5:0] FN_SYSCALL = 6'd12;
  localparam logic [5:0] FN_MFHI    = 6'd16;
  localparam logic [5:0] FN_MTHI    = 6'd17;
  localparam logic [5:0] FN_MFLO    = 6'd18;
  localparam logic [5:0] FN_MTLO    = 6'd19;
  localparam logic [5:0] FN_MULT    = 6'd24;
  localparam logic [5:0] FN_MULTU   = 6'd25;
  localparam logic [5:0] FN_DIV     = 6'd26;
  localparam logic [5:0] FN_DIVU    = 6'd27;
  localparam logic [5:0] FN_ADD     = 6'd32;
  localparam logic [5:0] FN_ADDU    = 6'd33;
  localparam logic [5:0] FN_SUB     = 6'd34;
  localparam logic [5:0] FN_SUBU    = 6'd35;
  localparam logic [5:0] FN_AND     = 6'd36;
  localparam logic [5:0] FN_OR      = 6'd37;
  localparam logic [5:0] FN_XOR     = 6'd38;
  localparam logic [5:0] FN_NOR     = 6'd39;
  localparam logic [5:0] FN_SLT     = 6'd42;
  localparam logic [5:0] FN_SLTU    = 6'd43;

  // rt codes of the regimm opcode
  localparam logic [4:0] RI_BLTZ    = 5'd0;
  localparam logic [4:0] RI_BGEZ    = 5'd1;
  localparam logic [4:0] RI_BLTZAL  = 5'd16;
  localparam logic [4:0] RI_BGEZAL  = 5'd17;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,   // zero the data store after reset
    ST_IDLE,    // wait for an instruction word
    ST_EXEC,    // operands valid, execute or launch a long operation
    ST_DIV,     // shared restoring divider, one bit a cycle
    ST_DFIN,    // apply divide result or reduced address
    ST_WR,      // write one store byte
    ST_RD,      // read one data byte
    ST_CAP,     // capture the byte read
    ST_DONE     // commit and hand the result word over
  } mie_state_t;

endpackage

### hdl/mips_instruction_execute_top.sv
// MIPS32 execute block: register file, HI/LO, PC, halt flag and byte data store.
//
// One instruction word is taken per handshake and produces one result word.
// After reset the block zeroes the data store, one byte a cycle, before the
// first instruction is taken. Operands come from the register file memory
// in the cycle after the word is taken; ALU ops, shifts, jumps, branches,
// HI/LO moves, multiplies and syscalls then pass through the execute and
// done states to the result register, and the next word is taken only once
// the sequencer is back in idle. Divides by a nonzero divisor also pass
// through the shared restoring divider. Loads and stores first reduce the
// effective address modulo the store size with a reciprocal multiply, a take
// back and one correcting subtract, then go through the single byte-wide
// data port: a load reads and captures each of its bytes in turn, a store
// writes each of its bytes and then reads back the stored word.
// The next word is taken as soon as the sequencer is idle, while the
// previous result may still wait at the output.
module mips_instruction_execute_top
  import mie_pkg::*;
#(
  parameter int DATA_STORE_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  // instruction channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] instruction,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] next_pc,
  output logic        halted,
  output logic        reg_write_enable,
  output logic [4:0]  reg_write_index,
  output logic [31:0] reg_write_value,
  output logic [31:0] hi_value,
  output logic [31:0] lo_value,
  output logic        store_enable,
  output logic [31:0] store_address,
  output logic [31:0] store_word
);

  localparam int          AW     = $clog2(DATA_STORE_BYTES);
  localparam logic [AW:0] NSUM   = (AW+1)'(DATA_STORE_BYTES);
  localparam logic [AW-1:0] CLR_LAST = AW'(DATA_STORE_BYTES - 1);
  localparam logic [31:0] DIV_N  = 32'(DATA_STORE_BYTES);
  localparam logic [31:0] RECIP  = 32'((64'd1 << 32) / DATA_STORE_BYTES);

  mie_state_t state, state_next;

  // architectural state
  logic [31:0] start_addr;
  logic [31:0] pc;
  logic [31:0] hi;
  logic [31:0] lo;
  logic        halt;
  logic        boot;
  logic [31:0] rf_valid;

  // current instruction
  logic [31:0] ins;
  logic [5:0]  op, fn;
  logic [4:0]  rs, rt, rd, sh;
  logic [15:0] zimm;
  logic [31:0] simm;

  // register file read side
  logic [31:0] rf_qa, rf_qb;
  logic        va, vb;
  logic [31:0] a, b;
  logic [4:0]  ra_in;
  logic        accept;

  // working result
  logic        w_we;
  logic [4:0]  w_idx;
  logic [31:0] w_val;
  logic [31:0] w_npc;
  logic        mem_go;

  // execute decode
  logic        ex_we;
  logic [4:0]  ex_idx;
  logic [31:0] ex_val;
  logic [31:0] ex_npc;
  mie_state_t  ex_next;
  logic [31:0] pc4, btarget, jtarget;
  logic        sgn;
  logic signed [65:0] prod;

  // divider
  logic [31:0] dv_rem, dv_quo, dv_div;
  logic [4:0]  dv_cnt;
  logic        dv_mem, dv_negq, dv_negr;
  logic [33:0] dv_diff;

  // address reduction
  logic [63:0] rc_prod;
  logic [31:0] rc_back;

  // data store access
  logic [AW-1:0] base;
  logic [2:0]    mcnt;
  logic [2:0]    mlen, rlen;
  logic [AW:0]   msum;
  logic [AW-1:0] maddr;
  logic [31:0]   mword;
  logic          is_load, is_store;
  logic [AW-1:0] clr_cnt;
  logic          dm_we;
  logic [AW-1:0] dm_waddr;
  logic [7:0]    dm_wdata;
  logic [7:0]    dm_q;

  // commit
  logic          fire;
  logic          fwe;
  logic [4:0]    fidx;
  logic [31:0]   fval;
  logic [31:0]   ldval;
  logic          s_en;

  logic [31:0] rf  [32];
  logic [7:0]  dmem [DATA_STORE_BYTES];

  // Split the held word into its fields
  assign op   = ins[31:26];
  assign rs   = ins[25:21];
  assign rt   = ins[20:16];
  assign rd   = ins[15:11];
  assign sh   = ins[10:6];
  assign fn   = ins[5:0];
  assign zimm = ins[15:0];
  assign simm = {{16{ins[15]}}, ins[15:0]};

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = !boot;
  assign accept    = in_valid && in_ready;

  // Syscall reads v0 through the rs port
  assign ra_in = (instruction[31:26] == OP_SPECIAL && instruction[5:0] == FN_SYSCALL)
                 ? REG_V0 : instruction[25:21];

  // Unwritten registers read as zero
  assign a = va ? rf_qa : 32'd0;
  assign b = vb ? rf_qb : 32'd0;

  assign pc4     = pc + 32'd4;
  assign btarget = pc4 + {simm[29:0], 2'b00};
  assign jtarget = {pc4[31:28], ins[25:0], 2'b00};
  assign sgn     = (fn == FN_MULT) || (fn == FN_DIV);
  assign prod    = $signed({sgn & a[31], a}) * $signed({sgn & b[31], b});

  assign is_load  = op inside {OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU};
  assign is_store = op inside {OP_SB, OP_SH, OP_SW};

  // Access length in bytes
  always_comb begin
    case (op)
      OP_LB, OP_LBU, OP_SB: mlen = 3'd1;
      OP_LH, OP_LHU, OP_SH: mlen = 3'd2;
      default:              mlen = 3'd4;
    endcase
  end
  assign rlen = is_store ? 3'd4 : mlen;

  // Byte address, wrapped once around the store
  assign msum  = {1'b0, base} + (AW+1)'(mcnt);
  assign maddr = (msum >= NSUM) ? AW'(msum - NSUM) : msum[AW-1:0];

  // One restoring divide step
  assign dv_diff = {1'b0, dv_rem, dv_quo[31]} - {2'b00, dv_div};

  // Quotient estimate of the address and its take back
  assign rc_prod = {32'd0, dv_quo} * {32'd0, RECIP};
  assign rc_back = dv_rem * DIV_N;

  // Decode and execute the short instructions
  always_comb begin
    ex_we   = 1'b0;
    ex_idx  = rd;
    ex_val  = 32'd0;
    ex_npc  = pc4;
    ex_next = ST_DONE;
    if (halt) begin
      ex_npc = pc;
    end else begin
      case (op)
        OP_SPECIAL: begin
          case (fn)
            FN_SLL:  begin ex_we = 1'b1; ex_val = b << sh; end
            FN_SRL:  begin ex_we = 1'b1; ex_val = b >> sh; end
            FN_SRA:  begin ex_we = 1'b1; ex_val = 32'($signed(b) >>> sh); end
            FN_SLLV: begin ex_we = 1'b1; ex_val = b << a[4:0]; end
            FN_SRLV: begin ex_we = 1'b1; ex_val = b >> a[4:0]; end
            FN_SRAV: begin ex_we = 1'b1; ex_val = 32'($signed(b) >>> a[4:0]); end
            FN_JR:   ex_npc = a;
            FN_JALR: begin ex_npc = a; ex_we = 1'b1; ex_val = pc4; end
            FN_MFHI: begin ex_we = 1'b1; ex_val = hi; end
            FN_MFLO: begin ex_we = 1'b1; ex_val = lo; end
            FN_DIV, FN_DIVU: begin
              if (b != 32'd0) ex_next = ST_DIV;
            end
            FN_ADD, FN_ADDU: begin ex_we = 1'b1; ex_val = a + b; end
            FN_SUB, FN_SUBU: begin ex_we = 1'b1; ex_val = a - b; end
            FN_AND:  begin ex_we = 1'b1; ex_val = a & b; end
            FN_OR:   begin ex_we = 1'b1; ex_val = a | b; end
            FN_XOR:  begin ex_we = 1'b1; ex_val = a ^ b; end
            FN_NOR:  begin ex_we = 1'b1; ex_val = ~(a | b); end
            FN_SLT:  begin ex_we = 1'b1; ex_val = {31'd0, $signed(a) < $signed(b)}; end
            FN_SLTU: begin ex_we = 1'b1; ex_val = {31'd0, a < b}; end
            default: ;
          endcase
        end
        OP_REGIMM: begin
          case (rt)
            RI_BLTZ: if (a[31]) ex_npc = btarget;
            RI_BGEZ: if (!a[31]) ex_npc = btarget;
            RI_BLTZAL: begin
              ex_we = 1'b1; ex_idx = REG_RA; ex_val = pc4;
              if (a[31]) ex_npc = btarget;
            end
            RI_BGEZAL: begin
              ex_we = 1'b1; ex_idx = REG_RA; ex_val = pc4;
              if (!a[31]) ex_npc = btarget;
            end
            default: ;
          endcase
        end
        OP_J:    ex_npc = jtarget;
        OP_JAL:  begin ex_npc = jtarget; ex_we = 1'b1; ex_idx = REG_RA; ex_val = pc4; end
        OP_BEQ:  if (a == b) ex_npc = btarget;
        OP_BNE:  if (a != b) ex_npc = btarget;
        OP_BLEZ: if (a == 32'd0 || a[31]) ex_npc = btarget;
        OP_BGTZ: if (a != 32'd0 && !a[31]) ex_npc = btarget;
        OP_ADDI, OP_ADDIU: begin ex_we = 1'b1; ex_idx = rt; ex_val = a + simm; end
        OP_SLTI:  begin
          ex_we = 1'b1; ex_idx = rt; ex_val = {31'd0, $signed(a) < $signed(simm)};
        end
        OP_SLTIU: begin ex_we = 1'b1; ex_idx = rt; ex_val = {31'd0, a < simm}; end
        OP_ANDI:  begin ex_we = 1'b1; ex_idx = rt; ex_val = a & {16'd0, zimm}; end
        OP_ORI:   begin ex_we = 1'b1; ex_idx = rt; ex_val = a | {16'd0, zimm}; end
        OP_XORI:  begin ex_we = 1'b1; ex_idx = rt; ex_val = a ^ {16'd0, zimm}; end
        OP_LUI:   begin ex_we = 1'b1; ex_idx = rt; ex_val = {zimm, 16'd0}; end
        OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU, OP_SB, OP_SH, OP_SW: ex_next = ST_DIV;
        default: ;
      endcase
    end
    // register zero never takes a write
    if (ex_idx == 5'd0) ex_we = 1'b0;
  end

  // Sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_cnt == CLR_LAST) state_next = ST_IDLE;
      ST_IDLE:  if (accept) state_next = ST_EXEC;
      ST_EXEC:  state_next = ex_next;
      ST_DIV:   if (dv_cnt == 5'd31 || (dv_mem && dv_cnt == 5'd2)) state_next = ST_DFIN;
      ST_DFIN:  state_next = !dv_mem ? ST_DONE : (is_store ? ST_WR : ST_RD);
      ST_WR:    if (mcnt == mlen - 3'd1) state_next = ST_RD;
      ST_RD:    state_next = ST_CAP;
      ST_CAP:   state_next = (mcnt == rlen - 3'd1) ? ST_DONE : ST_RD;
      ST_DONE:  if (fire) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Hold the sequencer state
  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else     state <= state_next;
  end

  // Load value from the gathered bytes
  always_comb begin
    case (op)
      OP_LB:   ldval = {{24{mword[7]}}, mword[7:0]};
      OP_LH:   ldval = {{16{mword[15]}}, mword[15:0]};
      OP_LBU:  ldval = {24'd0, mword[7:0]};
      OP_LHU:  ldval = {16'd0, mword[15:0]};
      default: ldval = mword;
    endcase
  end

  assign fire = (state == ST_DONE) && (!out_valid || out_ready);
  assign s_en = mem_go && is_store;
  assign fwe  = (mem_go && is_load) ? (rt != 5'd0) : w_we;
  assign fidx = (mem_go && is_load) ? rt : w_idx;
  assign fval = (mem_go && is_load) ? ldval : w_val;

  // Data store port
  always_comb begin
    dm_we    = 1'b0;
    dm_waddr = maddr;
    dm_wdata = b[{mcnt[1:0], 3'b000} +: 8];
    if (state == ST_CLEAR) begin
      dm_we    = 1'b1;
      dm_waddr = clr_cnt;
      dm_wdata = 8'd0;
    end else if (state == ST_WR) begin
      dm_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (dm_we) dmem[dm_waddr] <= dm_wdata;
    dm_q <= dmem[maddr];
  end

  // Register file memory, read on acceptance, written on commit
  always_ff @(posedge clk) begin
    if (fire && fwe) rf[fidx] <= fval;
    if (accept) begin
      rf_qa <= rf[ra_in];
      rf_qb <= rf[instruction[20:16]];
    end
  end

  // Control and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_addr <= START_RESET;
      boot       <= 1'b1;
      hi         <= 32'd0;
      lo         <= 32'd0;
      halt       <= 1'b0;
      rf_valid   <= 32'd0;
      clr_cnt    <= '0;
      out_valid  <= 1'b0;
      mem_go     <= 1'b0;
    end else begin
      // load PC from the start register in the first cycle out of reset
      if (boot) begin
        pc   <= start_addr;
        boot <= 1'b0;
      end
      if (cfg_valid && cfg_ready) start_addr <= cfg_data;
      if (state == ST_CLEAR) clr_cnt <= clr_cnt + AW'(1);

      if (accept) begin
        ins    <= instruction;
        va     <= rf_valid[ra_in];
        vb     <= rf_valid[instruction[20:16]];
        mem_go <= 1'b0;
      end

      // execute: latch short results, update HI/LO and halt, launch the divider
      if (state == ST_EXEC) begin
        w_we  <= ex_we;
        w_idx <= ex_idx;
        w_val <= ex_val;
        w_npc <= ex_npc;
        if (!halt && op == OP_SPECIAL) begin
          case (fn)
            FN_SYSCALL: if (a == EXIT_CODE) halt <= 1'b1;
            FN_MTHI: hi <= a;
            FN_MTLO: lo <= a;
            FN_MULT, FN_MULTU: begin
              hi <= prod[63:32];
              lo <= prod[31:0];
            end
            default: ;
          endcase
        end
        if (ex_next == ST_DIV) begin
          dv_rem <= 32'd0;
          dv_cnt <= 5'd0;
          if (is_load || is_store) begin
            dv_mem <= 1'b1;
            mem_go <= 1'b1;
            dv_quo <= a + simm;
            dv_div <= DIV_N;
          end else begin
            dv_mem  <= 1'b0;
            dv_quo  <= (sgn && a[31]) ? 32'd0 - a : a;
            dv_div  <= (sgn && b[31]) ? 32'd0 - b : b;
            dv_negq <= sgn && (a[31] ^ b[31]);
            dv_negr <= sgn && a[31];
          end
        end
      end

      // advance the divider one quotient bit, or reduce the address
      if (state == ST_DIV) begin
        dv_cnt <= dv_cnt + 5'd1;
        if (dv_mem) begin
          // estimate the quotient low by at most one, take back, correct once
          case (dv_cnt)
            5'd0:    dv_rem <= rc_prod[63:32];
            5'd1:    dv_rem <= dv_quo - rc_back;
            default: if (dv_rem >= DIV_N) dv_rem <= dv_rem - DIV_N;
          endcase
        end else if (!dv_diff[33]) begin
          dv_rem <= dv_diff[31:0];
          dv_quo <= {dv_quo[30:0], 1'b1};
        end else begin
          dv_rem <= {dv_rem[30:0], dv_quo[31]};
          dv_quo <= {dv_quo[30:0], 1'b0};
        end
      end

      if (state == ST_DFIN) begin
        if (dv_mem) begin
          base  <= dv_rem[AW-1:0];
          mcnt  <= 3'd0;
          mword <= 32'd0;
        end else begin
          lo <= dv_negq ? 32'd0 - dv_quo : dv_quo;
          hi <= dv_negr ? 32'd0 - dv_rem : dv_rem;
        end
      end

      if (state == ST_WR) begin
        mcnt <= (mcnt == mlen - 3'd1) ? 3'd0 : mcnt + 3'd1;
      end

      if (state == ST_CAP) begin
        mword[{mcnt[1:0], 3'b000} +: 8] <= dm_q;
        mcnt <= mcnt + 3'd1;
      end

      // commit and present the result word; drop it once taken
      if (fire) begin
        out_valid        <= 1'b1;
        pc               <= w_npc;
        next_pc          <= w_npc;
        halted           <= halt;
        hi_value         <= hi;
        lo_value         <= lo;
        reg_write_enable <= fwe;
        reg_write_index  <= fwe ? fidx : 5'd0;
        reg_write_value  <= fwe ? fval : 32'd0;
        store_enable     <= s_en;
        store_address    <= s_en ? 32'(base) : 32'd0;
        store_word       <= s_en ? mword : 32'd0;
        if (fwe) rf_valid[fidx] <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Checks
  a_wr_store_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(reg_write_enable && store_enable))
    else $error("register write and store in one result word");

  a_halt_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && halted |-> !reg_write_enable && !store_enable)
    else $error("state changed while halted");

  a_store_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && store_enable |-> store_address < DIV_N)
    else $error("store address outside data store");

  a_no_reg0: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (reg_write_enable == (reg_write_index != 5'd0)))
    else $error("register zero reported or index lost");

  a_exec_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_EXEC)
    else $error("accepted word not executed");

endmodule
